/* src/mvise_pkg.sv */
package mvise_pkg;

  // stream selector codes
  typedef enum logic [1:0] {
    REQ_U      = 2'd0,
    REQ_V      = 2'd1,
    REQ_HEIGHT = 2'd2,
    REQ_INDEX  = 2'd3
  } req_type_t;

  // configuration register indexes
  typedef enum logic {
    CFG_MIN_HEIGHT   = 1'b0,
    CFG_HEIGHT_SCALE = 1'b1
  } cfg_idx_t;

  localparam int unsigned COORD_W  = 15;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned HEIGHT_W = 32;
  localparam int unsigned SCALE_W  = 40;
  localparam int unsigned PROD_W   = HEIGHT_W + SCALE_W;

  localparam logic [SCALE_W-1:0]  SCALE_RESET = 40'd2147418112;
  localparam logic [COORD_W-1:0]  Q_MAX       = 15'h7FFF;
  localparam logic [PROD_W-1:0]   ROUND_HALF  = 72'h80_0000;

  // item fields that travel alongside the height pipeline
  typedef struct packed {
    req_type_t           req_type;
    logic                first;
    logic [COORD_W-1:0]  coord;
    logic [CODE_W-1:0]   vertex_index;
  } item_t;

  // per-stage load strobes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_ld_t;

endpackage

/* src/mesh_vertex_index_stream_encoder.sv */
// Terrain mesh stream encoder: one 16-bit code word per input transfer. u, v and
// height items give the zigzag delta against their stream's previous value,
// index items give high-water-mark codes with a violation flag. The block takes
// one item every cycle while the output is not stalled; each result passes the
// input register, height difference, split multiply, round and clamp and result
// register stages; the 32x40 height scaling is cut into a 32x32 and a 32x8 partial
// product in one stage and summed in the next. Non-height items ride the same
// stages so results stay in order. Configuration writes are always taken and
// must only happen while no item is in flight.
module mesh_vertex_index_stream_encoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_req_type,
  input  logic                                  in_first,
  input  logic [mvise_pkg::COORD_W-1:0]         in_coord,
  input  logic signed [mvise_pkg::HEIGHT_W-1:0] in_height_value,
  input  logic [mvise_pkg::CODE_W-1:0]          in_vertex_index,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mvise_pkg::CODE_W-1:0]          out_code_word,
  output logic                                  out_mark_violation,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [mvise_pkg::SCALE_W-1:0]         cfg_data
);

  logic signed [mvise_pkg::HEIGHT_W-1:0] min_height_r;
  logic [mvise_pkg::SCALE_W-1:0]         height_scale_r;

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;
  mvise_pkg::stage_ld_t ld;
  logic ld_out;

  mvise_pkg::item_t item_in;
  mvise_pkg::item_t it1_r, it2_r, it3_r, it4_r;
  logic [mvise_pkg::COORD_W-1:0] q;

  logic [mvise_pkg::COORD_W-1:0] prev_u_r, prev_v_r, prev_height_r;
  logic [mvise_pkg::CODE_W-1:0]  high_water_r;
  logic [mvise_pkg::COORD_W-1:0] prev_u_nxt, prev_v_nxt, prev_height_nxt;
  logic [mvise_pkg::CODE_W-1:0]  high_water_nxt;
  logic [mvise_pkg::COORD_W-1:0] zz_cur, zz_prev;
  logic [mvise_pkg::CODE_W-1:0]  zz_delta, zz_code;
  logic [mvise_pkg::CODE_W-1:0]  hw_base, hw_code;
  logic [mvise_pkg::CODE_W-1:0]  code_nxt, code_r;
  logic                          viol_nxt, viol_r;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_height_r   <= '0;
      height_scale_r <= mvise_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (mvise_pkg::cfg_idx_t'(cfg_index))
        mvise_pkg::CFG_MIN_HEIGHT:   min_height_r   <= cfg_data[31:0];
        mvise_pkg::CFG_HEIGHT_SCALE: height_scale_r <= cfg_data;
        default:                     height_scale_r <= height_scale_r;
      endcase
    end
  end

  // pipeline flow control, bubbles collapse
  assign rdy_o    = !out_valid_r || out_ready;
  assign rdy4     = !v4_r || rdy_o;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign ld.s1  = in_valid && rdy1;
  assign ld.s2  = v1_r && rdy2;
  assign ld.s3  = v2_r && rdy3;
  assign ld.s4  = v3_r && rdy4;
  assign ld_out = v4_r && rdy_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= ld.s1 || (v1_r && !ld.s2);
      v2_r        <= ld.s2 || (v2_r && !ld.s3);
      v3_r        <= ld.s3 || (v3_r && !ld.s4);
      v4_r        <= ld.s4 || (v4_r && !ld_out);
      out_valid_r <= ld_out || (out_valid_r && !out_ready);
    end
  end

  // item fields travel with the height pipeline
  assign item_in.req_type     = mvise_pkg::req_type_t'(in_req_type);
  assign item_in.first        = in_first;
  assign item_in.coord        = in_coord;
  assign item_in.vertex_index = in_vertex_index;

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      it1_r <= item_in;
    end
    if (ld.s2) begin
      it2_r <= it1_r;
    end
    if (ld.s3) begin
      it3_r <= it2_r;
    end
    if (ld.s4) begin
      it4_r <= it3_r;
    end
  end

  // height quantizer
  mvise_hquant u_hquant (
    .clk          (clk),
    .ld           (ld),
    .height_value (in_height_value),
    .min_height   (min_height_r),
    .height_scale (height_scale_r),
    .q            (q)
  );

  // zigzag of the selected vertex stream
  always_comb begin
    case (it4_r.req_type)
      mvise_pkg::REQ_U: begin
        zz_cur  = it4_r.coord;
        zz_prev = it4_r.first ? '0 : prev_u_r;
      end
      mvise_pkg::REQ_V: begin
        zz_cur  = it4_r.coord;
        zz_prev = it4_r.first ? '0 : prev_v_r;
      end
      mvise_pkg::REQ_HEIGHT: begin
        zz_cur  = q;
        zz_prev = it4_r.first ? '0 : prev_height_r;
      end
      default: begin
        zz_cur  = '0;
        zz_prev = '0;
      end
    endcase
  end

  assign zz_delta = {1'b0, zz_cur} - {1'b0, zz_prev};
  assign zz_code  = {zz_delta[14:0], 1'b0} ^ {16{zz_delta[15]}};

  // high-water-mark coding
  assign hw_base = it4_r.first ? '0 : high_water_r;
  assign hw_code = hw_base - it4_r.vertex_index;

  // result and stream state update
  always_comb begin
    prev_u_nxt      = prev_u_r;
    prev_v_nxt      = prev_v_r;
    prev_height_nxt = prev_height_r;
    high_water_nxt  = high_water_r;
    code_nxt        = zz_code;
    viol_nxt        = 1'b0;
    case (it4_r.req_type)
      mvise_pkg::REQ_U:      prev_u_nxt      = zz_cur;
      mvise_pkg::REQ_V:      prev_v_nxt      = zz_cur;
      mvise_pkg::REQ_HEIGHT: prev_height_nxt = zz_cur;
      default: begin
        code_nxt       = hw_code;
        viol_nxt       = it4_r.vertex_index > hw_base;
        high_water_nxt = (hw_code == '0) ? it4_r.vertex_index + 16'd1 : hw_base;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_u_r      <= '0;
      prev_v_r      <= '0;
      prev_height_r <= '0;
      high_water_r  <= '0;
    end else if (ld_out) begin
      prev_u_r      <= prev_u_nxt;
      prev_v_r      <= prev_v_nxt;
      prev_height_r <= prev_height_nxt;
      high_water_r  <= high_water_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ld_out) begin
      code_r <= code_nxt;
      viol_r <= viol_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_code_word      = code_r;
  assign out_mark_violation = viol_r;

endmodule

/* src/mvise_hquant.sv */
module mvise_hquant (
  input  logic                                  clk,
  input  mvise_pkg::stage_ld_t                  ld,
  input  logic signed [mvise_pkg::HEIGHT_W-1:0] height_value,
  input  logic signed [mvise_pkg::HEIGHT_W-1:0] min_height,
  input  logic [mvise_pkg::SCALE_W-1:0]         height_scale,
  output logic [mvise_pkg::COORD_W-1:0]         q
);

  logic signed [mvise_pkg::HEIGHT_W-1:0] hv_r;
  logic [mvise_pkg::HEIGHT_W:0]          diff;
  logic                                  pos_nxt;
  logic                                  pos2_r;
  logic [mvise_pkg::HEIGHT_W-1:0]        ud_r;
  logic [63:0]                           pp_lo_nxt;
  logic [63:0]                           pp_lo_r;
  logic [39:0]                           pp_hi_nxt;
  logic [39:0]                           pp_hi_r;
  logic                                  pos3_r;
  logic [mvise_pkg::PROD_W-1:0]          prod;
  logic [mvise_pkg::PROD_W-1:0]          rnd;
  logic                                  sat;
  logic [mvise_pkg::COORD_W-1:0]         q_nxt;
  logic [mvise_pkg::COORD_W-1:0]         q_r;

  // stage 2: exact 33-bit difference against the tile minimum
  assign diff    = {hv_r[31], hv_r} - {min_height[31], min_height};
  assign pos_nxt = !diff[32] && (diff[31:0] != '0);

  // stage 3: split the 32x40 product into two partial products
  assign pp_lo_nxt = 64'(ud_r) * 64'(height_scale[31:0]);
  assign pp_hi_nxt = 40'(ud_r) * 40'(height_scale[39:32]);

  // stage 4: recombine, round half up, saturate
  assign prod  = 72'(pp_lo_r) + {pp_hi_r, 32'b0};
  assign rnd   = prod + mvise_pkg::ROUND_HALF;
  assign sat   = |rnd[71:39];
  assign q_nxt = !pos3_r ? '0 : (sat ? mvise_pkg::Q_MAX : rnd[38:24]);

  // data stages, no reset needed
  always_ff @(posedge clk) begin
    if (ld.s1) begin
      hv_r <= height_value;
    end
    if (ld.s2) begin
      pos2_r <= pos_nxt;
      ud_r   <= diff[31:0];
    end
    if (ld.s3) begin
      pos3_r  <= pos2_r;
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
    end
    if (ld.s4) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* verif/tb_mesh_vertex_index_stream_encoder.sv */
`timescale 1ns / 1ps

module tb_mesh_vertex_index_stream_encoder;
  import mvise_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 50_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned REPORT_MAX = 10;

  // one expected code word and its flag
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              violation;
  } coded_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [1:0]                 in_req_type;
  logic                       in_first;
  logic [COORD_W-1:0]         in_coord;
  logic signed [HEIGHT_W-1:0] in_height_value;
  logic [CODE_W-1:0]          in_vertex_index;
  logic                       out_valid;
  logic                       out_ready;
  logic [CODE_W-1:0]          out_code_word;
  logic                       out_mark_violation;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic                       cfg_index;
  logic [SCALE_W-1:0]         cfg_data;

  // encoder state as the testbench tracks it
  logic [COORD_W-1:0]         last_u;
  logic [COORD_W-1:0]         last_v;
  logic [COORD_W-1:0]         last_height_q;
  logic [CODE_W-1:0]          index_mark;
  logic signed [HEIGHT_W-1:0] tile_min_height;
  logic [SCALE_W-1:0]         tile_height_scale;

  coded_result_t pending_codes[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_left;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned cfg_writes;
  int unsigned cycle_count;

  mesh_vertex_index_stream_encoder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_first           (in_first),
    .in_coord           (in_coord),
    .in_height_value    (in_height_value),
    .in_vertex_index    (in_vertex_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_code_word      (out_code_word),
    .out_mark_violation (out_mark_violation),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_mesh_vertex_index_stream_encoder: done, errors");
    $finish;
  end

  // height quantized against the tile minimum and scale, saturating
  function automatic logic [COORD_W-1:0] quantize_height(logic signed [HEIGHT_W-1:0] hv);
    logic signed [HEIGHT_W+1:0] diff;
    logic [79:0]                prod;
    diff = {{2{hv[HEIGHT_W-1]}}, hv}
         - {{2{tile_min_height[HEIGHT_W-1]}}, tile_min_height};
    if (diff <= 0 || tile_height_scale == '0) begin
      return '0;
    end
    prod = {47'd0, diff[HEIGHT_W:0]} * {40'd0, tile_height_scale} + 80'h80_0000;
    prod = prod >> 24;
    if (prod > 80'(Q_MAX)) begin
      return Q_MAX;
    end
    return prod[COORD_W-1:0];
  endfunction

  function automatic logic [CODE_W-1:0] zigzag(logic [COORD_W-1:0] cur,
                                               logic [COORD_W-1:0] prv);
    int          delta;
    logic [31:0] z;
    delta = int'(cur) - int'(prv);
    if (delta >= 0) begin
      z = 32'(delta * 2);
    end else begin
      z = 32'(-delta * 2 - 1);
    end
    return z[CODE_W-1:0];
  endfunction

  // work out the code word for an accepted item and queue it
  task automatic predict_code(req_type_t kind, logic first, logic [COORD_W-1:0] coord,
                              logic [HEIGHT_W-1:0] hv, logic [CODE_W-1:0] idx);
    coded_result_t    r;
    logic [COORD_W-1:0] q;
    r.violation = 1'b0;
    case (kind)
      REQ_U: begin
        if (first) last_u = '0;
        r.code = zigzag(coord, last_u);
        last_u = coord;
      end
      REQ_V: begin
        if (first) last_v = '0;
        r.code = zigzag(coord, last_v);
        last_v = coord;
      end
      REQ_HEIGHT: begin
        if (first) last_height_q = '0;
        q = quantize_height(hv);
        r.code = zigzag(q, last_height_q);
        last_height_q = q;
      end
      default: begin
        if (first) index_mark = '0;
        r.violation = (idx > index_mark);
        r.code = index_mark - idx;
        if (r.code == '0) index_mark = idx + 16'd1;
      end
    endcase
    pending_codes = {pending_codes, r};
  endtask

  // one item transfer, called at a falling edge, returns at a falling edge
  task automatic send_item(req_type_t kind, logic first, logic [COORD_W-1:0] coord,
                           logic [HEIGHT_W-1:0] hv, logic [CODE_W-1:0] idx);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= kind;
    in_first        <= first;
    in_coord        <= coord;
    in_height_value <= hv;
    in_vertex_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_code(kind, first, coord, hv, idx);
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait until every queued code word has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t which, logic [SCALE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (which == CFG_MIN_HEIGHT) begin
      tile_min_height = data[HEIGHT_W-1:0];
    end else begin
      tile_height_scale = data;
    end
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic apply_config(logic [HEIGHT_W-1:0] min_h, logic [SCALE_W-1:0] scale);
    wait_idle();
    // upper bits of the minimum are junk the block must drop
    write_cfg(CFG_MIN_HEIGHT, {8'($urandom), min_h});
    write_cfg(CFG_HEIGHT_SCALE, scale);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] next_coord(logic [COORD_W-1:0] prv);
    int v;
    case ($urandom_range(0, 9))
      7, 8: return COORD_W'($urandom);
      9: return ($urandom_range(0, 1) != 0) ? Q_MAX : '0;
      default: begin
        v = int'(prv) + int'($urandom_range(0, 128)) - 64;
        if (v < 0) v = 0;
        if (v > int'(Q_MAX)) v = int'(Q_MAX);
        return COORD_W'(v);
      end
    endcase
  endfunction

  // heights mostly inside the span that maps onto 0..32767
  function automatic logic [HEIGHT_W-1:0] pick_height();
    logic [63:0] span;
    case ($urandom_range(0, 9))
      6, 7: return $urandom;
      8: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      9: return tile_min_height + 32'($urandom_range(0, 4)) - 32'd2;
      default: begin
        if (tile_height_scale == '0) begin
          span = 64'd1 << 20;
        end else begin
          span = ((64'd32767 << 24) / {24'd0, tile_height_scale}) + 64'd64;
        end
        if (span > 64'hFFFF_FFF0) span = 64'hFFFF_FFF0;
        return tile_min_height + $urandom_range(0, span[31:0]) - 32'd32;
      end
    endcase
  endfunction

  // triangle corners: mostly new vertices or recent ones, some past the mark
  function automatic logic [CODE_W-1:0] pick_index();
    int unsigned r;
    logic [CODE_W-1:0] lo;
    r = $urandom_range(0, 99);
    if (r < 50) return index_mark;
    if (r < 85) begin
      if (index_mark == '0) return '0;
      lo = (index_mark > 16'd16) ? index_mark - 16'd16 : '0;
      return CODE_W'($urandom_range(lo, index_mark - 16'd1));
    end
    if (r < 95) return index_mark + CODE_W'($urandom_range(1, 4));
    return CODE_W'($urandom);
  endfunction

  // stray item of any kind between well-formed streams
  task automatic maybe_noise(inout int unsigned sent);
    if ($urandom_range(0, 11) == 0) begin
      send_item(req_type_t'($urandom_range(0, 3)), $urandom_range(0, 15) == 0,
                COORD_W'($urandom), $urandom, CODE_W'($urandom));
      sent++;
    end
  endtask

  // checker: each result transfer against the oldest expectation
  always @(posedge clk) begin
    coded_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (pending_codes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("result %0d with nothing pending: code 0x%04h violation %0b",
                   results_checked, out_code_word, out_mark_violation);
      end else begin
        want = pending_codes.pop_front();
        if (out_code_word !== want.code) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("result %0d code_word: expected 0x%04h, got 0x%04h",
                     results_checked, want.code, out_code_word);
        end
        if (out_mark_violation !== want.violation) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("result %0d mark_violation: expected %0b, got %0b",
                     results_checked, want.violation, out_mark_violation);
        end
      end
    end
  end

  // receiver: random stalls plus counted hold-off stretches
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // field extremes, restarts, unused fields and the mark cases
  task automatic test_directed();
    send_item(REQ_U, 1'b1, 15'd0, $urandom, CODE_W'($urandom));
    send_item(REQ_U, 1'b0, Q_MAX, $urandom, CODE_W'($urandom));
    send_item(REQ_U, 1'b0, 15'd0, $urandom, CODE_W'($urandom));
    send_item(REQ_U, 1'b1, 15'd5, 32'h7FFF_FFFF, 16'hFFFF);
    send_item(REQ_V, 1'b1, Q_MAX, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(REQ_V, 1'b0, 15'd0, 32'h8000_0000, 16'h0000);
    send_item(REQ_HEIGHT, 1'b1, Q_MAX, 32'd1, 16'hFFFF);
    send_item(REQ_HEIGHT, 1'b0, 15'd0, 32'h7FFF_FFFF, CODE_W'($urandom));
    send_item(REQ_HEIGHT, 1'b0, Q_MAX, 32'h8000_0000, CODE_W'($urandom));
    send_item(REQ_HEIGHT, 1'b0, COORD_W'($urandom), 32'd0, CODE_W'($urandom));
    send_item(REQ_HEIGHT, 1'b1, COORD_W'($urandom), 32'd100, CODE_W'($urandom));
    send_item(REQ_INDEX, 1'b1, Q_MAX, $urandom, 16'd0);
    send_item(REQ_INDEX, 1'b0, 15'd0, $urandom, 16'd1);
    send_item(REQ_INDEX, 1'b0, COORD_W'($urandom), $urandom, 16'd0);
    send_item(REQ_INDEX, 1'b0, COORD_W'($urandom), $urandom, 16'd5);
    send_item(REQ_INDEX, 1'b0, COORD_W'($urandom), $urandom, 16'hFFFE);
    // index past the legal range is coded like the rest
    send_item(REQ_INDEX, 1'b0, COORD_W'($urandom), $urandom, 16'hFFFF);
    send_item(REQ_INDEX, 1'b0, COORD_W'($urandom), $urandom, 16'd2);
    send_item(REQ_INDEX, 1'b1, COORD_W'($urandom), $urandom, 16'd0);
    send_item(REQ_U, 1'b0, 15'd1, $urandom, CODE_W'($urandom));
  endtask

  // random tiles: u, v and height streams, then triangle corners
  task automatic test_mesh_tiles(int unsigned item_goal);
    int unsigned        sent;
    int unsigned        nv;
    int unsigned        ntri;
    bit                 broken;
    logic [COORD_W-1:0] c;
    req_type_t          s;
    sent = 0;
    while (sent < item_goal) begin
      nv = $urandom_range(3, 24);
      // some tiles leave the restart flag off
      broken = ($urandom_range(0, 9) == 0);
      for (int si = 0; si < 2; si++) begin
        s = (si == 0) ? REQ_U : REQ_V;
        c = COORD_W'($urandom);
        for (int k = 0; k < int'(nv); k++) begin
          maybe_noise(sent);
          if (k != 0) c = next_coord(c);
          send_item(s, (k == 0) && !broken, c, $urandom, CODE_W'($urandom));
          sent++;
        end
      end
      for (int k = 0; k < int'(nv); k++) begin
        maybe_noise(sent);
        send_item(REQ_HEIGHT, (k == 0) && !broken, COORD_W'($urandom), pick_height(),
                  CODE_W'($urandom));
        sent++;
      end
      ntri = $urandom_range(1, nv);
      for (int k = 0; k < int'(3 * ntri); k++) begin
        maybe_noise(sent);
        send_item(REQ_INDEX, (k == 0) && !broken, COORD_W'($urandom), $urandom,
                  pick_index());
        sent++;
      end
    end
  endtask

  // receiver stops for a long stretch while items keep coming, then a full drain
  task automatic test_output_hold_off();
    hold_off_left = 80;
    for (int k = 0; k < 40; k++) begin
      send_item(req_type_t'($urandom_range(0, 3)), $urandom_range(0, 7) == 0,
                COORD_W'($urandom), pick_height(), pick_index());
    end
    wait_idle();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_req_type     = REQ_U;
    in_first        = 1'b0;
    in_coord        = '0;
    in_height_value = '0;
    in_vertex_index = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_MIN_HEIGHT;
    cfg_data        = '0;
    hold_off_left   = 0;
    items_sent      = 0;
    results_checked = 0;
    mismatch_count  = 0;
    cfg_writes      = 0;
    last_u            = '0;
    last_v            = '0;
    last_height_q     = '0;
    index_mark        = '0;
    tile_min_height   = '0;
    tile_height_scale = SCALE_RESET;
    send_idle_pct   = 38;
    recv_idle_pct   = 49;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset configuration first
    test_directed();
    test_mesh_tiles(350);
    apply_config(32'h8000_0000, 40'hFF_FFFF_FFFF);
    test_mesh_tiles(100);

    send_idle_pct = 49;
    recv_idle_pct = 38;
    apply_config(32'h7FFF_FFFF, 40'd0);
    test_mesh_tiles(100);
    apply_config($urandom, 40'd1);
    test_mesh_tiles(60);
    apply_config($urandom, 40'd2147418);
    test_mesh_tiles(300);
    test_output_hold_off();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_config(-32'sd256000, 40'd1073709);
    test_mesh_tiles(400);

    wait_idle();
    $display("covered %0d items and %0d register writes across six tile settings,",
             items_sent, cfg_writes);
    $display("%0d code words checked, with restarts, stray items and mark violations",
             results_checked);
    if (mismatch_count == 0) begin
      $display("tb_mesh_vertex_index_stream_encoder: done, clean");
    end else begin
      $display("tb_mesh_vertex_index_stream_encoder: done, errors");
    end
    $finish;
  end

endmodule
